// File: hw/rtl/canny_gradient_nms_threshold_macros.svh
// Assertion macros for the edge detector back end.
// Each macro expands to one labeled concurrent assertion on clk with rst_n low as disable.
`ifndef CANNY_GRADIENT_NMS_THRESHOLD_MACROS_SVH
`define CANNY_GRADIENT_NMS_THRESHOLD_MACROS_SVH

// condition holds at every edge out of reset
`define CGNT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CGNT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CGNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cgnt_pkg.sv
// Shared types and constants of the edge detector back end.
// No dependencies; imported by cgnt_front, cgnt_back and the top level.
package cgnt_pkg;

  // input word opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // quantized gradient direction
  localparam logic [1:0] DIR_0  = 2'd0;
  localparam logic [1:0] DIR_45 = 2'd1;
  localparam logic [1:0] DIR_90 = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd3;

  localparam int GRAD_W = 8;
  localparam int MAG_W  = 8;

  // front to back word
  typedef struct packed {
    logic             drain;
    logic [1:0]       dir;
    logic [MAG_W-1:0] mag;
  } mid_word_t;

  // result word
  typedef struct packed {
    logic is_edge;
    logic frame_end;
  } res_word_t;

  // configuration registers
  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [7:0]  low;
    logic [7:0]  high;
  } cfg_t;

  // neighbor step: -1, 0 or +1
  typedef logic signed [1:0] step_t;

  // 3x3 window scan, row step of entry k (raster order)
  function automatic step_t win_dr(input logic [3:0] k);
    step_t r;
    case (k)
      4'd0, 4'd1, 4'd2: r = -2'sd1;
      4'd3, 4'd4, 4'd5: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  // 3x3 window scan, column step of entry k
  function automatic step_t win_dc(input logic [3:0] k);
    step_t r;
    case (k)
      4'd0, 4'd3, 4'd6: r = -2'sd1;
      4'd1, 4'd4, 4'd7: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/cgnt_queue.sv
// Small first-in first-out queue with queue-style handshakes.
// Depends on nothing; used between front and back and on the result side.
module cgnt_queue #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// File: hw/rtl/cgnt_front.sv
// Front end: accepts input words, computes magnitude and direction code.
// Depends on cgnt_pkg; feeds the front-to-back queue.
module cgnt_front import cgnt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_opcode,
  input  logic [GRAD_W-1:0] in_grad_x,
  input  logic [GRAD_W-1:0] in_grad_y,
  output logic              mid_push,
  input  logic              mid_full,
  output mid_word_t         mid_word
);

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} fstate_t;

  localparam logic [3:0] STEP_ROOT0 = 4'd4;
  localparam logic [3:0] STEP_LAST  = 4'd11;

  fstate_t           state_r;
  logic [3:0]        step_r;
  logic [GRAD_W-1:0] gx_r;
  logic [GRAD_W-1:0] gy_r;
  logic [15:0]       sx_r;
  logic [16:0]       s_r;
  logic              dir0_r;
  logic              dir1_r;
  logic [MAG_W-1:0]  root_r;
  mid_word_t         word_r;

  // one shared 9x9 multiplier, operand picked by step
  logic [8:0]       mul_op;
  logic [17:0]      prod;
  logic [MAG_W-1:0] trial;
  logic [MAG_W-1:0] root_upd;

  assign trial    = root_r | (8'h80 >> 3'(step_r - STEP_ROOT0));
  assign root_upd = (prod <= 18'(s_r)) ? trial : root_r;

  always_comb begin
    case (step_r)
      4'd0:    mul_op = {1'b0, gx_r};
      4'd1:    mul_op = {1'b0, gy_r};
      4'd2:    mul_op = {1'b0, gx_r} + {1'b0, gy_r};
      4'd3:    mul_op = (gy_r > gx_r) ? {1'b0, gy_r - gx_r} : 9'd0;
      default: mul_op = {1'b0, trial};
    endcase
  end

  assign prod = mul_op * mul_op;

  assign in_full  = (state_r != F_IDLE);
  assign mid_push = (state_r == F_PUSH);
  assign mid_word = word_r;

  // sequencer: squares first, then a bit-per-step square root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            gx_r   <= in_grad_x;
            gy_r   <= in_grad_y;
            root_r <= '0;
            step_r <= '0;
            if (in_opcode == OP_DRAIN) begin
              word_r  <= '{drain: 1'b1, dir: DIR_0, mag: '0};
              state_r <= F_PUSH;
            end else begin
              state_r <= F_CALC;
            end
          end
        end
        F_CALC: begin
          case (step_r)
            4'd0:    sx_r   <= prod[15:0];
            4'd1:    s_r    <= {1'b0, sx_r} + prod[16:0];
            4'd2:    dir0_r <= (prod <= 18'({sx_r, 1'b0}));
            4'd3:    dir1_r <= (gy_r <= gx_r) || (prod <= 18'({sx_r, 1'b0}));
            default: root_r <= root_upd;
          endcase
          if (step_r == STEP_LAST) begin
            word_r.drain <= 1'b0;
            word_r.mag   <= s_r[16] ? 8'hFF : root_upd;
            word_r.dir   <= dir0_r ? DIR_0 : (dir1_r ? DIR_45 : DIR_90);
            state_r      <= F_PUSH;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        F_PUSH: begin
          if (!mid_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/cgnt_back.sv
// Back end: line rings, non-maximum suppression and double threshold.
// Depends on cgnt_pkg and the assertion macro header.
`include "canny_gradient_nms_threshold_macros.svh"

module cgnt_back import cgnt_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  mid_word_t mid_word,
  input  logic      mid_empty,
  output logic      mid_pop,
  output logic      out_push,
  input  logic      out_full,
  output res_word_t out_word
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int RING = 2 * MAX_WIDTH + 4;
  localparam int AW   = $clog2(RING);

  typedef enum logic [3:0] {
    S_IDLE, S_LATCH, S_TOTAL, S_WRITE, S_NCHK, S_NRD, S_NUSE, S_NSAVE,
    S_OCHK, S_ORD, S_OUSE, S_OPUSH
  } bstate_t;

  bstate_t          state_r;
  logic             drain_r;
  logic [MAG_W-1:0] mag_r;
  logic [1:0]       dir_r;

  logic [WW-1:0] fw_r;
  logic [HW-1:0] fh_r;
  logic [PW-1:0] total_r;

  logic [PW-1:0] in_pos_r,  nms_pos_r,  out_pos_r;
  logic [AW-1:0] in_ring_r, nms_ring_r, out_ring_r;
  logic [HW-1:0] nms_row_r, out_row_r;
  logic [WW-1:0] nms_col_r, out_col_r;

  logic [3:0]       k_r;
  logic             in_ok_r;
  logic [MAG_W-1:0] cv_r;
  logic [1:0]       cdir_r;
  logic             keep_r;
  logic             hit_r;

  // line rings
  logic [9:0]       mag_mem [RING];
  logic [MAG_W-1:0] sup_mem [RING];
  logic [9:0]       mag_rd_r;
  logic [MAG_W-1:0] sup_rd_r;

  // clamped geometry from the registers
  logic [WW-1:0] cw_clamp;
  logic [HW-1:0] ch_clamp;
  always_comb begin
    if (cfg.width == '0)                         cw_clamp = WW'(1);
    else if (32'(cfg.width) > 32'(MAX_WIDTH))    cw_clamp = WW'(MAX_WIDTH);
    else                                         cw_clamp = WW'(cfg.width);
    if (cfg.height == '0)                        ch_clamp = HW'(1);
    else if (32'(cfg.height) > 32'(MAX_HEIGHT))  ch_clamp = HW'(MAX_HEIGHT);
    else                                         ch_clamp = HW'(cfg.height);
  end

  // neighbor step for the current read
  step_t dr, dc;
  always_comb begin
    dr = 2'sd0;
    dc = 2'sd0;
    if (state_r == S_ORD) begin
      dr = win_dr(k_r);
      dc = win_dc(k_r);
    end else if (k_r != 4'd0) begin
      case (cdir_r)
        DIR_0: begin
          dr = 2'sd0;
          dc = (k_r == 4'd1) ? -2'sd1 : 2'sd1;
        end
        DIR_45: begin
          dr = (k_r == 4'd1) ? -2'sd1 : 2'sd1;
          dc = (k_r == 4'd1) ? 2'sd1 : -2'sd1;
        end
        default: begin
          dr = (k_r == 4'd1) ? -2'sd1 : 2'sd1;
          dc = 2'sd0;
        end
      endcase
    end
  end

  // ring address and in-image test for the neighbor
  logic [AW-1:0]         base_ring;
  logic [HW-1:0]         base_row;
  logic [WW-1:0]         base_col;
  logic signed [AW+1:0]  fw_s, off_s, sum_s;
  logic [AW-1:0]         rd_addr;
  logic                  row_ok, col_ok;

  assign base_ring = (state_r == S_ORD) ? out_ring_r : nms_ring_r;
  assign base_row  = (state_r == S_ORD) ? out_row_r  : nms_row_r;
  assign base_col  = (state_r == S_ORD) ? out_col_r  : nms_col_r;
  assign fw_s      = $signed((AW+2)'(fw_r));

  always_comb begin
    off_s = (dr < 0) ? -fw_s : ((dr > 0) ? fw_s : '0);
    off_s = off_s + (AW+2)'(dc);
    sum_s = $signed((AW+2)'(base_ring)) + off_s;
    if (sum_s < 0)
      rd_addr = AW'(sum_s + (AW+2)'(RING));
    else if (sum_s >= (AW+2)'(RING))
      rd_addr = AW'(sum_s - (AW+2)'(RING));
    else
      rd_addr = AW'(sum_s);
    row_ok = (dr < 0) ? (base_row != '0) :
             ((dr > 0) ? ((HW+1)'(base_row) + (HW+1)'(1) < (HW+1)'(fh_r)) : 1'b1);
    col_ok = (dc < 0) ? (base_col != '0) :
             ((dc > 0) ? ((WW+1)'(base_col) + (WW+1)'(1) < (WW+1)'(fw_r)) : 1'b1);
  end

  // progress limits
  logic [PW:0] nms_lim, out_lim, nms_reach, out_reach;
  assign nms_reach = (PW+1)'(nms_pos_r) + (PW+1)'(fw_r) + (PW+1)'(2);
  assign out_reach = (PW+1)'(out_pos_r) + (PW+1)'(fw_r) + (PW+1)'(2);
  assign nms_lim   = (nms_reach < (PW+1)'(total_r)) ? nms_reach : (PW+1)'(total_r);
  assign out_lim   = (out_reach < (PW+1)'(total_r)) ? out_reach : (PW+1)'(total_r);

  logic [MAG_W-1:0] nms_val, thr_val;
  assign nms_val = in_ok_r ? mag_rd_r[MAG_W-1:0] : '0;
  assign thr_val = in_ok_r ? sup_rd_r : '0;

  logic last_px;
  assign last_px = (out_pos_r == total_r - PW'(1));

  assign mid_pop  = (state_r == S_IDLE) && !mid_empty;
  assign out_push = (state_r == S_OPUSH);
  assign out_word = '{is_edge: !(cv_r < cfg.low) && hit_r, frame_end: last_px};

  // ring memories, registered read
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && !drain_r && in_pos_r < total_r) begin
      mag_mem[in_ring_r] <= {dir_r, mag_r};
    end
    if (state_r == S_NSAVE) begin
      sup_mem[nms_ring_r] <= keep_r ? cv_r : '0;
    end
    mag_rd_r <= mag_mem[rd_addr];
    sup_rd_r <= sup_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fw_r       <= WW'(1);
      fh_r       <= HW'(1);
      total_r    <= PW'(1);
      in_pos_r   <= '0;
      nms_pos_r  <= '0;
      out_pos_r  <= '0;
      in_ring_r  <= '0;
      nms_ring_r <= '0;
      out_ring_r <= '0;
      nms_row_r  <= '0;
      nms_col_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      k_r        <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!mid_empty) begin
            drain_r <= mid_word.drain;
            mag_r   <= mid_word.mag;
            dir_r   <= mid_word.dir;
            state_r <= S_LATCH;
          end
        end
        S_LATCH: begin
          if (!drain_r && in_pos_r == '0 && out_pos_r == '0) begin
            fw_r <= cw_clamp;
            fh_r <= ch_clamp;
          end
          state_r <= S_TOTAL;
        end
        S_TOTAL: begin
          total_r <= PW'(fw_r) * PW'(fh_r);
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (!drain_r && in_pos_r < total_r) begin
            in_pos_r  <= in_pos_r + PW'(1);
            in_ring_r <= (in_ring_r == AW'(RING - 1)) ? '0 : in_ring_r + AW'(1);
          end
          state_r <= S_NCHK;
        end
        S_NCHK: begin
          k_r <= '0;
          if (nms_pos_r < total_r && (PW+1)'(in_pos_r) >= nms_lim) begin
            state_r <= S_NRD;
          end else begin
            state_r <= S_OCHK;
          end
        end
        S_NRD: begin
          in_ok_r <= row_ok && col_ok;
          state_r <= S_NUSE;
        end
        S_NUSE: begin
          if (k_r == 4'd0) begin
            cv_r   <= mag_rd_r[MAG_W-1:0];
            cdir_r <= mag_rd_r[9:8];
            keep_r <= 1'b1;
          end else if (!(cv_r > nms_val)) begin
            keep_r <= 1'b0;
          end
          if (k_r == 4'd2) begin
            state_r <= S_NSAVE;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_NRD;
          end
        end
        S_NSAVE: begin
          nms_pos_r  <= nms_pos_r + PW'(1);
          nms_ring_r <= (nms_ring_r == AW'(RING - 1)) ? '0 : nms_ring_r + AW'(1);
          if (nms_col_r == fw_r - WW'(1)) begin
            nms_col_r <= '0;
            nms_row_r <= nms_row_r + HW'(1);
          end else begin
            nms_col_r <= nms_col_r + WW'(1);
          end
          state_r <= S_OCHK;
        end
        S_OCHK: begin
          k_r   <= '0;
          hit_r <= 1'b0;
          if (out_pos_r < total_r && (PW+1)'(nms_pos_r) >= out_lim) begin
            state_r <= S_ORD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_ORD: begin
          in_ok_r <= row_ok && col_ok;
          state_r <= S_OUSE;
        end
        S_OUSE: begin
          if (thr_val > cfg.high) hit_r <= 1'b1;
          if (k_r == 4'd4) cv_r <= thr_val;
          if (k_r == 4'd8) begin
            state_r <= S_OPUSH;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_ORD;
          end
        end
        S_OPUSH: begin
          if (!out_full) begin
            if (last_px) begin
              in_pos_r   <= '0;
              nms_pos_r  <= '0;
              out_pos_r  <= '0;
              in_ring_r  <= '0;
              nms_ring_r <= '0;
              out_ring_r <= '0;
              nms_row_r  <= '0;
              nms_col_r  <= '0;
              out_row_r  <= '0;
              out_col_r  <= '0;
            end else begin
              out_pos_r  <= out_pos_r + PW'(1);
              out_ring_r <= (out_ring_r == AW'(RING - 1)) ? '0 : out_ring_r + AW'(1);
              if (out_col_r == fw_r - WW'(1)) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + HW'(1);
              end else begin
                out_col_r <= out_col_r + WW'(1);
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `CGNT_ASSERT_ALWAYS(a_pos_order, (out_pos_r <= nms_pos_r) && (nms_pos_r <= in_pos_r), "position order broken")
  `CGNT_ASSERT_ALWAYS(a_in_bound, in_pos_r <= total_r, "input position past frame size")
  `CGNT_ASSERT_IMP(a_push_room, out_push, !out_full || state_r == S_OPUSH, "result push state slip")
  `CGNT_ASSERT_NEXT(a_frame_wrap, out_push && !out_full && out_word.frame_end, (in_pos_r == '0) && (out_pos_r == '0), "frame did not wrap")

endmodule

// File: hw/rtl/canny_gradient_nms_threshold.sv
// Top level of the edge detector back end: config registers, front, back, queues.
// Depends on cgnt_pkg, cgnt_queue, cgnt_front and cgnt_back.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------
//   input    | in_opcode, in_grad_x, in_grad_y         | in_push & !in_full
//   result   | out_is_edge, out_frame_end              | out_pop & !out_empty
//   config   | cfg_index, cfg_data                     | cfg_wr_en
//
// The front takes a pixel word through accept, 12 steps on one shared 9x9 multiplier
// (four squares and an 8-step square root) and hand-off; a drain word skips the steps.
// In the back the line rings have one read port and each window read takes a read and
// a use state, 3 reads for suppression and 9 for the threshold.
// A two-entry queue sits between front and back and another on the result side.
// Reset is synchronous and clears control only; the rings need no clearing pass.
module canny_gradient_nms_threshold import cgnt_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_opcode,
  input  logic [GRAD_W-1:0]     in_grad_x,
  input  logic [GRAD_W-1:0]     in_grad_y,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_is_edge,
  output logic                  out_frame_end,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MID_W = $bits(mid_word_t);
  localparam int RES_W = $bits(res_word_t);

  cfg_t      cfg_r;
  mid_word_t front_word, back_word;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  logic      res_push, res_full;
  res_word_t res_in, res_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{width: 11'd1024, height: 11'd1024, low: 8'd0, high: 8'd255};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_r.width  <= cfg_data;
        CFG_HEIGHT: cfg_r.height <= cfg_data;
        CFG_LOW:    cfg_r.low    <= cfg_data[7:0];
        CFG_HIGH:   cfg_r.high   <= cfg_data[7:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  cgnt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_opcode (in_opcode),
    .in_grad_x (in_grad_x),
    .in_grad_y (in_grad_y),
    .mid_push  (mid_push),
    .mid_full  (mid_full),
    .mid_word  (front_word)
  );

  cgnt_queue #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .full  (mid_full),
    .din   (front_word),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (back_word)
  );

  cgnt_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_word  (back_word),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_push  (res_push),
    .out_full  (res_full),
    .out_word  (res_in)
  );

  cgnt_queue #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_out)
  );

  assign out_is_edge   = res_out.is_edge;
  assign out_frame_end = res_out.frame_end;

endmodule

// File: bench/testbench.sv
// Self-checking bench for the edge detector back end (canny_gradient_nms_threshold).
// Depends on cgnt_pkg and the RTL of the block; drives words through both queue ports
// and checks every result word against an in-bench predictor.
module testbench;
  import cgnt_pkg::*;

  localparam int RING     = 2052;
  localparam int MAX_DIM  = 1024;
  localparam int HOLD_CYC = 400;
  localparam int SETTLE   = 200;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_opcode = OP_DRAIN;
  logic [GRAD_W-1:0]     in_grad_x = '0;
  logic [GRAD_W-1:0]     in_grad_y = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_is_edge;
  logic                  out_frame_end;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  canny_gradient_nms_threshold u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_grad_x(in_grad_x), .in_grad_y(in_grad_y),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_is_edge(out_is_edge), .out_frame_end(out_frame_end),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // expected result words, oldest first
  res_word_t edge_q[$];
  int        errs = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;
  int        sent_words = 0;

  // predictor state: register copies, latched geometry, line rings, positions
  logic [10:0] reg_w = 11'd1024, reg_h = 11'd1024;
  logic [7:0]  reg_lo = 8'd0, reg_hi = 8'd255;
  int unsigned fw = 1024, fh = 1024;
  int unsigned pos_in = 0, pos_nms = 0, pos_out = 0;
  logic [9:0]  mag_ring [RING];
  logic [7:0]  sup_ring [RING];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errs++;
  endtask

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // floor sqrt of gx^2+gy^2, saturated at 255
  function automatic logic [7:0] grad_mag(logic [7:0] x, logic [7:0] y);
    int unsigned s, r, t;
    s = x * x + y * y;
    r = 0;
    if (s >= 65536) return 8'd255;
    for (int b = 128; b > 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  // direction in exact integer form
  function automatic logic [1:0] grad_dir(logic [7:0] x, logic [7:0] y);
    int unsigned xx, yy;
    xx = x;
    yy = y;
    if ((xx + yy) * (xx + yy) <= 2 * xx * xx) return DIR_0;
    if (yy <= xx || (yy - xx) * (yy - xx) <= 2 * xx * xx) return DIR_45;
    return DIR_90;
  endfunction

  function automatic bit in_img(int r, int c);
    return r >= 0 && c >= 0 && r < int'(fh) && c < int'(fw);
  endfunction

  function automatic logic [9:0] mag_at(int r, int c);
    if (!in_img(r, c)) return '0;
    return mag_ring[(r * fw + c) % RING];
  endfunction

  function automatic logic [7:0] sup_at(int r, int c);
    if (!in_img(r, c)) return '0;
    return sup_ring[(r * fw + c) % RING];
  endfunction

  // keep a magnitude only if it beats both neighbors along its direction
  function automatic logic [7:0] nms_value(int unsigned q);
    int r, c;
    logic [9:0] e;
    logic [7:0] p1, p2;
    r = q / fw;
    c = q % fw;
    e = mag_at(r, c);
    case (e[9:8])
      DIR_0: begin
        p1 = 8'(mag_at(r, c - 1));
        p2 = 8'(mag_at(r, c + 1));
      end
      DIR_45: begin
        p1 = 8'(mag_at(r - 1, c + 1));
        p2 = 8'(mag_at(r + 1, c - 1));
      end
      default: begin
        p1 = 8'(mag_at(r - 1, c));
        p2 = 8'(mag_at(r + 1, c));
      end
    endcase
    return (e[7:0] > p1 && e[7:0] > p2) ? e[7:0] : 8'd0;
  endfunction

  // double threshold; a weak pixel is an edge if its 3x3 window holds a strong one
  function automatic bit edge_value(int unsigned o);
    int r, c;
    logic [7:0] v;
    r = o / fw;
    c = o % fw;
    v = sup_at(r, c);
    if (v < reg_lo) return 1'b0;
    if (v > reg_hi) return 1'b1;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (sup_at(r + dr, c + dc) > reg_hi) return 1'b1;
    return 1'b0;
  endfunction

  // advance the predictor by one accepted word
  task automatic predict_word(logic op, logic [7:0] gx, logic [7:0] gy,
                              output bit got, output res_word_t res);
    int unsigned total, lim;
    bit pix;
    pix = (op == OP_PIXEL);
    got = 1'b0;
    res = '0;
    if (pix && pos_in == 0 && pos_out == 0) begin
      fw = clamp_dim(reg_w);
      fh = clamp_dim(reg_h);
    end
    total = fw * fh;
    if (pix && pos_in < total) begin
      mag_ring[pos_in % RING] = {grad_dir(gx, gy), grad_mag(gx, gy)};
      pos_in++;
    end
    lim = (pos_nms + fw + 2 < total) ? pos_nms + fw + 2 : total;
    if (pos_nms < total && pos_in >= lim) begin
      sup_ring[pos_nms % RING] = nms_value(pos_nms);
      pos_nms++;
    end
    lim = (pos_out + fw + 2 < total) ? pos_out + fw + 2 : total;
    if (pos_out < total && pos_nms >= lim) begin
      got = 1'b1;
      res.is_edge = edge_value(pos_out);
      res.frame_end = (pos_out == total - 1);
      pos_out++;
      if (res.frame_end) begin
        pos_in = 0;
        pos_nms = 0;
        pos_out = 0;
      end
    end
  endtask

  // offer one word, wait for acceptance, then draw the gap before the next
  task automatic send_word(logic op, logic [7:0] gx, logic [7:0] gy,
                           bit typed = 0, bit t_edge = 0, bit t_end = 0);
    bit got;
    res_word_t res;
    int gap;
    in_push <= 1'b1;
    in_opcode <= op;
    in_grad_x <= gx;
    in_grad_y <= gy;
    do @(posedge clk); while (in_full);
    sent_words++;
    predict_word(op, gx, gy, got, res);
    if (typed) begin
      res.is_edge = t_edge;
      res.frame_end = t_end;
      got = 1'b1;
    end
    if (got) edge_q.push_back(res);
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write all four registers once the block has settled
  task automatic set_config(int w, int h, int lo, int hi);
    in_push <= 1'b0;
    wait (edge_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= w[10:0];
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h[10:0];
    @(posedge clk);
    cfg_index <= CFG_LOW;
    cfg_data <= {3'd0, lo[7:0]};
    @(posedge clk);
    cfg_index <= CFG_HIGH;
    cfg_data <= {3'd0, hi[7:0]};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_w = w[10:0];
    reg_h = h[10:0];
    reg_lo = lo[7:0];
    reg_hi = hi[7:0];
  endtask

  function automatic logic [7:0] pick_grad();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // finish the frame in progress with drains and surplus pixels
  task automatic flush_frame();
    while (pos_in != 0 || pos_out != 0) begin
      if ($urandom_range(0, 5) == 0) send_word(OP_PIXEL, pick_grad(), pick_grad());
      else send_word(OP_DRAIN, pick_grad(), pick_grad());
    end
  endtask

  // one random frame; idx selects the geometry extremes and the pressure cases
  task automatic run_frame(int idx);
    int w, h, lo, hi, npix;
    w = $urandom_range(1, 9);
    h = $urandom_range(1, 7);
    if (idx == 1) begin
      w = 6;
      h = 5;
    end
    if (idx == 2) begin
      w = 8;
      h = 8;
    end
    // zero width taken as one, height saturated at the maximum
    if (idx == 3) begin
      w = 0;
      h = 2047;
    end
    lo = $urandom_range(0, 255);
    hi = $urandom_range(0, 255);
    case ($urandom_range(0, 5))
      0: lo = 0;
      1: hi = 255;
      2: hi = 0;
      default: ;
    endcase
    set_config(w, h, lo, hi);
    quiet = ($urandom_range(0, 3) == 0);
    if (idx == 2) hold_req = 1'b1;
    npix = clamp_dim(w) * clamp_dim(h);
    for (int p = 0; p < npix; p++) begin
      if ($urandom_range(0, 7) == 0) send_word(OP_DRAIN, pick_grad(), pick_grad());
      if (idx == 1 && p == npix / 2) begin
        in_push <= 1'b0;
        wait (edge_q.size() == 0);
      end
      send_word(OP_PIXEL, pick_grad(), pick_grad());
    end
    flush_frame();
    if ($urandom_range(0, 3) == 0) send_word(OP_DRAIN, 8'd0, 8'd0);
  endtask

  // directed rows
  typedef struct {
    bit setc;
    int w, h, lo, hi;
    bit op;
    int gx, gy;
    bit typed, e, f;
  } row_t;

  row_t plan [22] = '{
    '{1, 1, 1, 0, 0,       OP_PIXEL, 0, 0,     1, 0, 1},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 255, 255, 1, 1, 1},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 255, 0,   1, 1, 1},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 0, 255,   1, 1, 1},
    '{0, 0, 0, 0, 0,       OP_DRAIN, 0, 0,     0, 0, 0},
    '{1, 0, 0, 255, 255,   OP_PIXEL, 255, 255, 1, 0, 1},
    '{1, 3, 3, 50, 150,    OP_PIXEL, 200, 10,  0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 10, 200,  0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 120, 120, 0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_DRAIN, 255, 255, 0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 255, 255, 0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 60, 25,   0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 25, 60,   0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 1, 0,     0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 0, 1,     0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 170, 85,  0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_DRAIN, 0, 0,     0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 77, 33,   0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_DRAIN, 0, 0,     0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_DRAIN, 0, 0,     0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_PIXEL, 255, 0,   0, 0, 0},
    '{0, 0, 0, 0, 0,       OP_DRAIN, 0, 0,     0, 0, 0}
  };

  // stimulus
  initial begin
    int idx;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].setc) set_config(plan[i].w, plan[i].h, plan[i].lo, plan[i].hi);
      send_word(plan[i].op, plan[i].gx, plan[i].gy, plan[i].typed, plan[i].e, plan[i].f);
    end
    flush_frame();
    idx = 0;
    while (sent_words < 1350) begin
      run_frame(idx);
      idx++;
    end
    in_push <= 1'b0;
    wait (edge_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errs == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // result side: random stalls, one long hold, and the check of each word
  initial begin
    int stall;
    res_word_t want;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty || !rst_n);
      if (edge_q.size() == 0) begin
        report("result word with none expected");
      end else begin
        want = edge_q.pop_front();
        if (out_is_edge !== want.is_edge)
          report($sformatf("is_edge %b, expected %b", out_is_edge, want.is_edge));
        if (out_frame_end !== want.frame_end)
          report($sformatf("frame_end %b, expected %b", out_frame_end, want.frame_end));
      end
    end
  end

endmodule
